// File: sv/aip_pkg.sv
// shared types, codes and character helpers for the ascii integer parser
`default_nettype none

package aip_pkg;

  typedef enum logic [2:0] {
    PhLead   = 3'd0,
    PhSign   = 3'd1,
    PhZero   = 3'd2,
    PhCheck  = 3'd3,
    PhDigits = 3'd4,
    PhTrail  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StOverflow = 3'd1,
    StNegative = 3'd2,
    StInvalid  = 3'd3,
    StBase     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ModeU32 = 2'd0,
    ModeU64 = 2'd1,
    ModeS32 = 2'd2,
    ModeRsv = 2'd3
  } mode_e;

  localparam int unsigned ValueW = 64;
  localparam int unsigned RadixW = 5;
  localparam int unsigned CharW  = 8;

  localparam logic [RadixW-1:0] BaseAuto = 5'd0;
  localparam logic [RadixW-1:0] BaseMin  = 5'd2;
  localparam logic [RadixW-1:0] BaseDec  = 5'd10;
  localparam logic [RadixW-1:0] BaseHex  = 5'd16;

  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  localparam logic [CharW-1:0] DigitNone = 8'hff;

  // configuration register indexes
  localparam logic [0:0] RegRadix = 1'b0;
  localparam logic [0:0] RegMode  = 1'b1;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
  } result_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [CharW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h7a)) begin
      d = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h5a)) begin
      d = c - 8'h37;
    end else begin
      d = DigitNone;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/aip_core.sv
// per-string parse state and the one-character step logic
`default_nettype none

module aip_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [aip_pkg::CharW-1:0]   char_i,
  input  wire logic                        last_i,
  input  wire logic [aip_pkg::RadixW-1:0]  radix_i,
  input  wire logic [1:0]                  mode_i,
  output aip_pkg::result_t                 result_o
);

  aip_pkg::phase_e              phase_q, phase_d;
  logic [aip_pkg::ValueW-1:0]   acc_q, acc_d;
  logic [aip_pkg::RadixW-1:0]   base_q, base_d;
  logic                         minus_q, minus_d;
  aip_pkg::status_e             err_q, err_d;
  aip_pkg::mode_e               mode_q, mode_d;

  logic [aip_pkg::CharW-1:0]    digit;
  logic [aip_pkg::ValueW+4:0]   acc_next;
  logic [aip_pkg::ValueW-1:0]   limit;
  logic [aip_pkg::ValueW-1:0]   neg_value;
  logic                         do_body;
  logic                         do_num;
  logic                         do_dig;
  logic                         spc;

  assign digit = aip_pkg::digit_of(char_i);
  assign spc   = aip_pkg::is_space(char_i);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    base_d   = base_q;
    minus_d  = minus_q;
    err_d    = err_q;
    mode_d   = mode_q;
    do_body  = 1'b0;
    do_num   = 1'b0;
    do_dig   = 1'b0;
    acc_next = '0;
    limit    = '0;

    if (err_q == aip_pkg::StOk) begin
      unique case (phase_q)
        aip_pkg::PhLead: begin
          mode_d = (mode_i == aip_pkg::ModeRsv) ? aip_pkg::ModeS32 : aip_pkg::mode_e'(mode_i);
          base_d = radix_i;
          if (!spc) begin
            if ((mode_d == aip_pkg::ModeS32) &&
                ((char_i == aip_pkg::ChMinus) || (char_i == aip_pkg::ChPlus))) begin
              minus_d = (char_i == aip_pkg::ChMinus);
              phase_d = aip_pkg::PhSign;
            end else begin
              do_body = 1'b1;
            end
          end
        end
        aip_pkg::PhSign: begin
          if (spc) begin
            err_d = aip_pkg::StInvalid;
          end else begin
            do_body = 1'b1;
          end
        end
        aip_pkg::PhZero: begin
          if ((char_i == aip_pkg::ChLowX) || (char_i == aip_pkg::ChUpX)) begin
            if (base_d == aip_pkg::BaseAuto) base_d = aip_pkg::BaseHex;
            phase_d = aip_pkg::PhCheck;
          end else begin
            if (base_d == aip_pkg::BaseAuto) base_d = aip_pkg::BaseDec;
            do_num = 1'b1;
          end
        end
        aip_pkg::PhCheck:  do_num = 1'b1;
        aip_pkg::PhDigits: do_dig = 1'b1;
        default: begin
          if (!spc) err_d = aip_pkg::StInvalid;
        end
      endcase

      if (do_body) begin
        if (((base_d == aip_pkg::BaseHex) || (base_d == aip_pkg::BaseAuto)) &&
            (char_i == aip_pkg::ChZero)) begin
          phase_d = aip_pkg::PhZero;
        end else begin
          if (base_d == aip_pkg::BaseAuto) base_d = aip_pkg::BaseDec;
          do_num = 1'b1;
        end
      end

      if (do_num) begin
        if ((base_d < aip_pkg::BaseMin) || (base_d > aip_pkg::BaseHex)) begin
          err_d = aip_pkg::StBase;
        end else if (char_i == aip_pkg::ChMinus) begin
          err_d = aip_pkg::StNegative;
        end else begin
          phase_d = aip_pkg::PhDigits;
          do_dig  = 1'b1;
        end
      end

      if (do_dig) begin
        if (digit < {3'b000, base_d}) begin
          unique case (mode_d)
            aip_pkg::ModeU32: limit = 64'h0000_0000_ffff_ffff;
            aip_pkg::ModeU64: limit = 64'hffff_ffff_ffff_ffff;
            default:          limit = minus_d ? 64'h0000_0000_8000_0000
                                              : 64'h0000_0000_7fff_ffff;
          endcase
          acc_next = ({5'd0, acc_q} * {64'd0, base_d}) + {61'd0, digit};
          if (acc_next > {5'd0, limit}) begin
            err_d = aip_pkg::StOverflow;
          end else begin
            acc_d = acc_next[aip_pkg::ValueW-1:0];
          end
        end else begin
          phase_d = aip_pkg::PhTrail;
          if (!spc) err_d = aip_pkg::StInvalid;
        end
      end
    end

    // end of string checks
    if (last_i && (err_d == aip_pkg::StOk)) begin
      if (phase_d == aip_pkg::PhSign) begin
        err_d = aip_pkg::StInvalid;
      end else if ((phase_d == aip_pkg::PhLead) && (mode_d != aip_pkg::ModeS32) &&
                   (base_d != aip_pkg::BaseAuto) &&
                   ((base_d < aip_pkg::BaseMin) || (base_d > aip_pkg::BaseHex))) begin
        err_d = aip_pkg::StBase;
      end
    end
  end

  // signed magnitude never exceeds 2^31, so a 32-bit negate suffices
  assign neg_value = {{32{acc_d != '0}}, (32'd0 - acc_d[31:0])};

  always_comb begin
    result_o.status = err_d;
    if (err_d != aip_pkg::StOk) begin
      result_o.value = '0;
    end else if ((mode_d == aip_pkg::ModeS32) && minus_d) begin
      result_o.value = neg_value;
    end else begin
      result_o.value = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aip_pkg::PhLead;
      acc_q   <= '0;
      base_q  <= '0;
      minus_q <= 1'b0;
      err_q   <= aip_pkg::StOk;
      mode_q  <= aip_pkg::ModeU32;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= aip_pkg::PhLead;
        acc_q   <= '0;
        base_q  <= '0;
        minus_q <= 1'b0;
        err_q   <= aip_pkg::StOk;
        mode_q  <= mode_d;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        base_q  <= base_d;
        minus_q <= minus_d;
        err_q   <= err_d;
        mode_q  <= mode_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ascii_integer_parser.sv
// top level: stream ports, input and result registers, config registers
//
// strings arrive one character per transfer on the s_axis channel, tlast on
// the final character. each string yields exactly one transfer on m_axis,
// made on its last character: tdata holds the 64-bit value and the 3-bit
// status. characters before the last one produce no output.
// the apb port sets radix (address 0) and result mode (address 4); write
// them only between strings.
// a character is held in the input register and parsed as it leaves it;
// the result of a string's last character is captured in the result
// register and offered on m_axis from there.
// throughput is one character per cycle outside the stall below, set by the
// combinational multiply-add and limit compare on the accumulator.
// a waiting result does not block parsing of the next string's characters;
// only a second last character stalls while the result register is full
// and m_axis_tready is low.
// reset empties both registers, sets radix 10 and signed 32-bit mode, and
// returns the parser to the leading whitespace phase.
`default_nettype none

module ascii_integer_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // last_char
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [71:0] m_axis_tdata,   // [63:0] value, [66:64] status, [71:67] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic                              in_valid_q;
  logic [aip_pkg::CharW-1:0]         in_char_q;
  logic                              in_last_q;
  logic                              out_valid_q;
  aip_pkg::result_t                  out_q;
  aip_pkg::result_t                  result;
  logic [aip_pkg::RadixW-1:0]        radix_q;
  logic [1:0]                        mode_q;
  logic                              step;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  assign step = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  aip_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .radix_i  (radix_q),
    .mode_i   (mode_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.status, out_q.value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= aip_pkg::BaseDec;
      mode_q  <= aip_pkg::ModeS32;
    end else if (cfg_wr && (paddr[1:0] == 2'b00)) begin
      unique case (paddr[2])
        aip_pkg::RegRadix: radix_q <= pwdata[aip_pkg::RadixW-1:0];
        aip_pkg::RegMode:  mode_q  <= pwdata[1:0];
        default:           radix_q <= radix_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        aip_pkg::RegRadix: prdata = {27'd0, radix_q};
        aip_pkg::RegMode:  prdata = {30'd0, mode_q};
        default:           prdata = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for ascii_integer_parser: directed and random strings checked against a parse predictor
module tb;
  import aip_pkg::*;

  localparam logic [2:0] AddrRadix = 3'd0;
  localparam logic [2:0] AddrMode  = 3'd4;
  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 3000;
  localparam int RandomPhases = 8;
  localparam int PhaseChars   = 50;
  localparam int DirRows      = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h0;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;   // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;          // [63:0] value, [66:64] status, [71:67] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copies of the registers and the parse state
  logic [4:0]  cfg_radix = BaseDec;
  mode_e       cfg_mode = ModeS32;
  phase_e      p_phase = PhLead;
  logic [63:0] p_acc = 64'd0;
  logic [4:0]  p_base = 5'd0;
  bit          p_neg = 1'b0;
  status_e     p_err = StOk;
  mode_e       p_mode = ModeU32;

  result_t     expected_parses[$];
  bit          fixed_valid = 1'b0;
  result_t     fixed_result;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          src_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  bit          hold_request = 1'b0;

  // directed strings; expectations typed in where fixed_row is set
  string       dir_text   [DirRows] = '{" \t", "-2147483648", "- ", "+", "-0", "--", "-1",
                                        "42 7", "0x", "0x-", "0X1f", "\013", " ", "-1",
                                        "\0019", "7\377"};
  logic [4:0]  dir_radix  [DirRows] = '{5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
                                        5'd10, 5'd16, 5'd16, 5'd0, 5'd1, 5'd31, 5'd2,
                                        5'd2, 5'd8};
  mode_e       dir_mode   [DirRows] = '{ModeS32, ModeS32, ModeS32, ModeS32, ModeS32, ModeS32,
                                        ModeU32, ModeU32, ModeU64, ModeS32, ModeU32, ModeU32,
                                        ModeS32, ModeRsv, ModeU32, ModeU64};
  bit          fixed_row  [DirRows] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 1};
  logic [63:0] dir_value  [DirRows] = '{64'd0, 64'hffff_ffff_8000_0000, 64'd0, 64'd0, 64'd0,
                                        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                                        64'd0, 64'd0, 64'd0, 64'd0};
  status_e     dir_status [DirRows] = '{StOk, StOk, StInvalid, StInvalid, StOk, StNegative,
                                        StNegative, StInvalid, StOk, StNegative, StOk, StBase,
                                        StOk, StOk, StInvalid, StInvalid};

  ascii_integer_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [63:0] limit_for(input mode_e m, input bit neg);
    case (m)
      ModeU32: return 64'hffff_ffff;
      ModeU64: return 64'hffff_ffff_ffff_ffff;
      default: return neg ? 64'h8000_0000 : 64'h7fff_ffff;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'(ChZero + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic digit_step(input logic [7:0] c);
    logic [63:0] d, b, top, cut;
    if (c >= "0" && c <= "9") d = 64'(c - "0");
    else if (c >= "a" && c <= "z") d = 64'(c - "a" + 10);
    else if (c >= "A" && c <= "Z") d = 64'(c - "A" + 10);
    else d = 64'hff;
    b = (p_base < BaseMin) ? 64'd2 : 64'(p_base);
    if (d < b) begin
      top = limit_for(p_mode, p_neg);
      cut = top / b;
      if (p_acc > cut || (p_acc == cut && d > top - cut * b)) p_err = StOverflow;
      else p_acc = p_acc * b + d;
    end else begin
      p_phase = PhTrail;
      if (!blank(c)) p_err = StInvalid;
    end
  endtask

  task automatic number_begin(input logic [7:0] c);
    if (p_base < BaseMin || p_base > BaseHex) begin
      p_err = StBase;
    end else if (c == ChMinus) begin
      p_err = StNegative;
    end else begin
      p_phase = PhDigits;
      digit_step(c);
    end
  endtask

  task automatic body_begin(input logic [7:0] c);
    if ((p_base == BaseHex || p_base == BaseAuto) && c == ChZero) begin
      p_phase = PhZero;
    end else begin
      if (p_base == BaseAuto) p_base = BaseDec;
      number_begin(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input bit last, output bit got,
                            output result_t r);
    got = 1'b0;
    r = '0;
    if (p_err == StOk) begin
      case (p_phase)
        PhLead: begin
          p_mode = (cfg_mode == ModeRsv) ? ModeS32 : cfg_mode;
          p_base = cfg_radix;
          if (!blank(c)) begin
            if (p_mode == ModeS32 && (c == ChMinus || c == ChPlus)) begin
              p_neg = (c == ChMinus);
              p_phase = PhSign;
            end else begin
              body_begin(c);
            end
          end
        end
        PhSign: begin
          if (blank(c)) p_err = StInvalid;
          else body_begin(c);
        end
        PhZero: begin
          if (c == ChLowX || c == ChUpX) begin
            if (p_base == BaseAuto) p_base = BaseHex;
            p_phase = PhCheck;
          end else begin
            if (p_base == BaseAuto) p_base = BaseDec;
            number_begin(c);
          end
        end
        PhCheck: number_begin(c);
        PhDigits: digit_step(c);
        default: if (!blank(c)) p_err = StInvalid;
      endcase
    end
    if (last) begin
      if (p_err == StOk) begin
        if (p_phase == PhSign) begin
          p_err = StInvalid;
        end else if (p_phase == PhLead && p_mode != ModeS32 && p_base != BaseAuto &&
                     (p_base < BaseMin || p_base > BaseHex)) begin
          p_err = StBase;
        end
      end
      r.status = p_err;
      if (p_err != StOk) r.value = 64'd0;
      else if (p_mode == ModeS32 && p_neg) r.value = 64'd0 - p_acc;
      else r.value = p_acc;
      got = 1'b1;
      p_phase = PhLead;
      p_acc = 64'd0;
      p_base = 5'd0;
      p_neg = 1'b0;
      p_err = StOk;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s expected %h got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    bit got;
    bit s_fire, m_fire;
    result_t r, want;
    if (rst_ni) begin
      s_fire = s_axis_tvalid && s_axis_tready;
      m_fire = m_axis_tvalid && m_axis_tready;
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrRadix) cfg_radix = pwdata[4:0];
        else if (paddr == AddrMode) cfg_mode = mode_e'(pwdata[1:0]);
      end
      if (s_fire) begin
        parse_char(s_axis_tdata, s_axis_tlast, got, r);
        if (got) begin
          if (fixed_valid) begin
            r = fixed_result;
            fixed_valid = 1'b0;
          end
          expected_parses.push_back(r);
        end
      end
      if (m_fire) begin
        if (expected_parses.size() == 0) begin
          report_mismatch("unexpected result transfer", 64'd0, m_axis_tdata[63:0]);
        end else begin
          want = expected_parses.pop_front();
          if (m_axis_tdata[63:0] !== want.value)
            report_mismatch("value", want.value, m_axis_tdata[63:0]);
          if (m_axis_tdata[66:64] !== want.status)
            report_mismatch("status", 64'(want.status), 64'(m_axis_tdata[66:64]));
        end
      end
      quiet_cycles <= (s_fire || m_fire) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure, plus one long hold on request
  always begin : sink
    @(negedge clk_i);
    if (hold_request) begin
      hold_request = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  task automatic send_string(input logic [7:0] chars[$]);
    foreach (chars[k]) begin
      if (src_gaps && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= chars[k];
      s_axis_tlast  <= (k == chars.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_parses.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  chars[$];
    logic [7:0]  digits[$];
    logic [63:0] top;
    logic [4:0]  pick_radix;
    mode_e       pick_mode;
    bit          neg;
    int          sent, kind, eff, low_digit;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;

    for (int row = 0; row < DirRows; row++) begin
      if (dir_radix[row] != cfg_radix || dir_mode[row] != cfg_mode) begin
        settle();
        if (dir_radix[row] != cfg_radix) apb_write(AddrRadix, 32'(dir_radix[row]));
        if (dir_mode[row] != cfg_mode) apb_write(AddrMode, 32'(dir_mode[row]));
      end
      fixed_valid = fixed_row[row];
      fixed_result = '{value: dir_value[row], status: dir_status[row]};
      chars.delete();
      for (int k = 0; k < dir_text[row].len(); k++) chars.push_back(dir_text[row][k]);
      send_string(chars);
    end

    for (int phase_no = 0; phase_no < RandomPhases; phase_no++) begin
      settle();
      case ($urandom_range(0, 7))
        0: pick_radix = BaseAuto;
        1: pick_radix = BaseHex;
        2: pick_radix = BaseDec;
        3: pick_radix = BaseMin;
        4: pick_radix = $urandom_range(0, 1) ? 5'd1 : 5'($urandom_range(17, 31));
        default: pick_radix = 5'($urandom_range(2, 16));
      endcase
      pick_mode = mode_e'($urandom_range(0, 3));
      apb_write(AddrRadix, 32'(pick_radix));
      apb_write(AddrMode, 32'(pick_mode));
      if (phase_no >= RandomPhases - 2) begin
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      if (phase_no == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < PhaseChars) begin
        chars.delete();
        neg = 1'b0;
        kind = $urandom_range(0, 9);
        eff = (cfg_radix >= BaseMin && cfg_radix <= BaseHex) ? int'(cfg_radix) : 10;
        repeat ($urandom_range(0, 2)) chars.push_back(pick_blank());
        if (kind == 0) begin
          // noise
          repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(1, 255)));
        end else begin
          if ($urandom_range(0, 3) == 0 || (cfg_mode >= ModeS32 && $urandom_range(0, 1))) begin
            neg = $urandom_range(0, 1);
            chars.push_back(neg ? ChMinus : ChPlus);
          end
          if ((cfg_radix == BaseHex || cfg_radix == BaseAuto) && $urandom_range(0, 1)) begin
            chars.push_back(ChZero);
            chars.push_back($urandom_range(0, 1) ? ChUpX : ChLowX);
            eff = 16;
          end
          if (kind == 1) begin
            // the limit of the mode spelled in the base, sometimes above it
            top = limit_for(cfg_mode, neg);
            low_digit = int'(top % eff);
            digits.delete();
            do begin
              digits.push_front(digit_char(int'(top % eff)));
              top = top / eff;
            end while (top != 0);
            if ($urandom_range(0, 1)) begin
              if (low_digit < eff - 1) digits[digits.size() - 1] = digit_char(low_digit + 1);
              else digits.push_back(ChZero);
            end
            chars = {chars, digits};
          end else begin
            repeat (kind == 3 ? $urandom_range(12, 22) : $urandom_range(1, 6))
              chars.push_back(digit_char($urandom_range(0, eff - 1)));
          end
          if (kind == 2) chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(1, 255));
        end
        repeat ($urandom_range(0, 2)) chars.push_back(pick_blank());
        send_string(chars);
        sent += chars.size();
      end
    end

    settle();
    if (mismatches == 0 && expected_parses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/aip_pkg.sv
sv/aip_core.sv
sv/ascii_integer_parser.sv
tb/tb.sv
